// File: src/slrs_pkg.sv
// ----------------------------------------------------------------------------
// slrs_pkg
// shared types, constants and the digit-to-bucket mapping for the signed
// lsd radix sorter
// ----------------------------------------------------------------------------
package slrs_pkg;

    localparam int DATA_W      = 32;
    localparam int NUM_BUCKETS = 512;
    localparam int BUCKET_W    = 9;
    localparam int NUM_PASSES  = 4;
    localparam int PASS_W      = 2;

    // input transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    // result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic                     overflow;
    } t_res;

    // bucket counter bank operations
    typedef enum logic [1:0] {
        BANK_CLEAR  = 2'd0,
        BANK_PREFIX = 2'd1,
        BANK_INC    = 2'd2,
        BANK_DEC    = 2'd3
    } t_bank_op;

    typedef struct packed {
        logic                valid;
        t_bank_op            op;
        logic [BUCKET_W-1:0] bucket;
    } t_bank_cmd;

    // byte digit of the pass, offset by 256 for nonnegative values
    function automatic logic [BUCKET_W-1:0] bucket_of(
        input logic [DATA_W-1:0] v,
        input logic [PASS_W-1:0] pass
    );
        logic [7:0] digit;
        begin
            case (pass)
                2'd0:    digit = v[7:0];
                2'd1:    digit = v[15:8];
                2'd2:    digit = v[23:16];
                default: digit = v[31:24];
            endcase
            return {~v[DATA_W-1], digit};
        end
    endfunction

endpackage

// File: src/slrs_bucket_bank.sv
// ----------------------------------------------------------------------------
// slrs_bucket_bank
// 512-entry bucket counter memory: clear sweep, prefix-sum sweep and
// single-entry increment / decrement with the new value returned
// ----------------------------------------------------------------------------
module slrs_bucket_bank #(
    parameter int CNT_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slrs_pkg::t_bank_cmd i_cmd,
    output logic               o_done,
    output logic [CNT_W-1:0]   o_pos
);
    import slrs_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CLEAR,
        B_PREFIX,
        B_RMW
    } t_bstate;

    t_bstate             r_state;
    logic [BUCKET_W-1:0] r_idx;
    logic [CNT_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_pos;
    logic                r_done;
    t_bank_op            r_op;
    logic [BUCKET_W-1:0] r_bucket;

    logic [CNT_W-1:0]    r_mem [NUM_BUCKETS];
    logic [CNT_W-1:0]    r_rdata;

    logic                rd_en;
    logic [BUCKET_W-1:0] rd_addr;
    logic                wr_en;
    logic [BUCKET_W-1:0] wr_addr;
    logic [CNT_W-1:0]    wr_data;
    logic [CNT_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_rmw;

    assign n_sum = r_sum + r_rdata;
    assign n_rmw = (r_op == BANK_INC) ? (r_rdata + CNT_W'(1)) : (r_rdata - CNT_W'(1));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx + BUCKET_W'(1);
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd.valid) begin
                    rd_en   = 1'b1;
                    rd_addr = (i_cmd.op == BANK_PREFIX) ? '0 : i_cmd.bucket;
                end
            end
            B_CLEAR: begin
                wr_en = 1'b1;
            end
            B_PREFIX: begin
                rd_en   = 1'b1;
                wr_en   = 1'b1;
                wr_data = n_sum;
            end
            B_RMW: begin
                wr_en   = 1'b1;
                wr_addr = r_bucket;
                wr_data = n_rmw;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op     <= i_cmd.op;
                        r_bucket <= i_cmd.bucket;
                        r_idx    <= '0;
                        r_sum    <= '0;
                        unique case (i_cmd.op)
                            BANK_CLEAR:  r_state <= B_CLEAR;
                            BANK_PREFIX: r_state <= B_PREFIX;
                            default:     r_state <= B_RMW;
                        endcase
                    end
                end
                B_CLEAR: begin
                    r_idx <= r_idx + BUCKET_W'(1);
                    if (&r_idx) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                B_PREFIX: begin
                    // inclusive running sum written back in place
                    r_sum <= n_sum;
                    r_idx <= r_idx + BUCKET_W'(1);
                    if (&r_idx) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                B_RMW: begin
                    r_pos   <= n_rmw;
                    r_done  <= 1'b1;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;

endmodule

// File: src/signed_lsd_radix_sort.sv
// ----------------------------------------------------------------------------
// signed_lsd_radix_sort
// sorts a set of signed 32-bit values into ascending order by four stable
// byte-digit counting passes over on-chip buffers
// ----------------------------------------------------------------------------
// usage
//   input channel: a transaction is taken at a clock edge where start is high
//   and busy is low. i_item.value is stored, i_item.last closes the set.
//   loading takes one transaction per cycle; busy stays low while loading.
//   values arriving with MAX_ITEMS already stored are dropped and the set is
//   flagged as overflowed (the last-marked value too; it still closes the set).
//   after the last transaction busy rises. each of the four passes clears the
//   512 bucket counters, counts the digits, forms the prefix sums and
//   scatters. the sort time is set by the 512-entry counter sweeps and the
//   read-modify-write handshake with the bucket counter memory.
//   results then leave one at a time on o_result, each valid for the
//   single cycle that o_strobe is high; the receiver cannot stall them. the
//   final one carries last_res. busy falls with the final result and the
//   next set can be loaded at once.
//   reset (synchronous, active low) empties the set and clears the overflow
//   flag; buffer contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module signed_lsd_radix_sort #(
    parameter int MAX_ITEMS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  slrs_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output slrs_pkg::t_res o_result
);
    import slrs_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLR,
        S_CNT_RD,
        S_CNT_BK,
        S_CNT_WT,
        S_PFX,
        S_SC_RD,
        S_SC_BK,
        S_SC_WT,
        S_OUT_RD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;    // stored values in the set
    logic                r_ovf;
    logic [PASS_W-1:0]   r_pass;
    logic [CW-1:0]       r_i;        // walk index over stored values
    logic [DATA_W-1:0]   r_val;      // value being scattered
    t_bank_cmd           r_cmd;
    logic                r_strobe;
    t_res                r_res;

    // ping-pong value buffers
    logic [DATA_W-1:0]   r_buf_a [MAX_ITEMS];
    logic [DATA_W-1:0]   r_buf_b [MAX_ITEMS];
    logic [DATA_W-1:0]   r_a_rdata;
    logic [DATA_W-1:0]   r_b_rdata;

    logic                bank_done;
    logic [CW-1:0]       bank_pos;

    logic                accept;
    logic                a_re;
    logic                b_re;
    logic                a_we;
    logic                b_we;
    logic [AW-1:0]       a_waddr;
    logic [AW-1:0]       b_waddr;
    logic [DATA_W-1:0]   a_wdata;
    logic [DATA_W-1:0]   src_data;
    logic [BUCKET_W-1:0] src_bucket;
    logic                src_rd;
    logic                scatter_wr;

    assign accept     = start && !busy;
    assign src_data   = r_pass[0] ? r_b_rdata : r_a_rdata;
    assign src_bucket = bucket_of(src_data, r_pass);

    // source is buffer a on even passes, b on odd; the sorted set ends in a
    assign src_rd     = (r_state == S_CNT_RD) || (r_state == S_SC_RD);
    assign a_re       = (src_rd && !r_pass[0]) || (r_state == S_OUT_RD);
    assign b_re       = src_rd && r_pass[0];
    assign scatter_wr = (r_state == S_SC_WT) && bank_done;

    always_comb begin
        a_we    = 1'b0;
        a_waddr = bank_pos[AW-1:0];
        a_wdata = r_val;
        if (accept && (r_count < CW'(MAX_ITEMS))) begin
            a_we    = 1'b1;
            a_waddr = r_count[AW-1:0];
            a_wdata = i_item.value;
        end else if (scatter_wr && r_pass[0]) begin
            a_we = 1'b1;
        end
    end

    assign b_we    = scatter_wr && !r_pass[0];
    assign b_waddr = bank_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (a_re) begin
            r_a_rdata <= r_buf_a[r_i[AW-1:0]];
        end
        if (a_we) begin
            r_buf_a[a_waddr] <= a_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_re) begin
            r_b_rdata <= r_buf_b[r_i[AW-1:0]];
        end
        if (b_we) begin
            r_buf_b[b_waddr] <= r_val;
        end
    end

    slrs_bucket_bank #(
        .CNT_W (CW)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_done  (bank_done),
        .o_pos   (bank_pos)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pass      <= '0;
            r_i         <= '0;
            r_cmd.valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_cmd.valid <= 1'b0;
            r_strobe    <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (r_count < CW'(MAX_ITEMS)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_pass  <= '0;
                            r_cmd   <= '{valid: 1'b1, op: BANK_CLEAR, bucket: '0};
                            r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    if (bank_done) begin
                        r_i     <= '0;
                        r_state <= S_CNT_RD;
                    end
                end
                S_CNT_RD: r_state <= S_CNT_BK;
                S_CNT_BK: begin
                    r_cmd   <= '{valid: 1'b1, op: BANK_INC, bucket: src_bucket};
                    r_state <= S_CNT_WT;
                end
                S_CNT_WT: begin
                    if (bank_done) begin
                        if (r_i == r_count - CW'(1)) begin
                            r_cmd   <= '{valid: 1'b1, op: BANK_PREFIX, bucket: '0};
                            r_state <= S_PFX;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_CNT_RD;
                        end
                    end
                end
                S_PFX: begin
                    // scatter walks backward to keep the pass stable
                    if (bank_done) begin
                        r_i     <= r_count - CW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: r_state <= S_SC_BK;
                S_SC_BK: begin
                    r_val   <= src_data;
                    r_cmd   <= '{valid: 1'b1, op: BANK_DEC, bucket: src_bucket};
                    r_state <= S_SC_WT;
                end
                S_SC_WT: begin
                    if (bank_done) begin
                        if (r_i == '0) begin
                            if (r_pass == PASS_W'(NUM_PASSES - 1)) begin
                                r_state <= S_OUT_RD;
                            end else begin
                                r_pass  <= r_pass + PASS_W'(1);
                                r_cmd   <= '{valid: 1'b1, op: BANK_CLEAR, bucket: '0};
                                r_state <= S_CLR;
                            end
                        end else begin
                            r_i     <= r_i - CW'(1);
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_OUT_RD: r_state <= S_OUT;
                S_OUT: begin
                    r_strobe              <= 1'b1;
                    r_res.sorted_value    <= r_a_rdata;
                    r_res.last_res        <= (r_i == r_count - CW'(1));
                    r_res.overflow        <= r_ovf;
                    if (r_i == r_count - CW'(1)) begin
                        // set done, back to loading with an empty set
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_OUT_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign busy     = (r_state != S_LOAD);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// File: test/signed_lsd_radix_sort_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_lsd_radix_sort_tb
// loads sets of signed values through the start/busy channel and checks every
// sorted result against a typed table row or an in-bench radix sort of the set
// ----------------------------------------------------------------------------
module signed_lsd_radix_sort_tb;

    import slrs_pkg::*;

    localparam int          SLOTS        = 64;        // MAX_ITEMS of the instance
    localparam int          DIR_N        = 18;
    localparam int          RAND_SETS    = 26;
    localparam int          DRAIN_CYCLES = 40;
    // slowest correct run: ~30 sets, each with its sort, its results and
    // sender gaps; taken several times over
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    // one row of the directed table; typed rows carry the result expected
    // at the same position of the sorted set
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        logic [DATA_W-1:0] exp_value;
        logic              exp_last;
    } dir_row_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    t_in    i_item;
    logic   busy;
    logic   o_strobe;
    t_res   o_result;

    // values held for the set being loaded, as the block holds them
    logic [DATA_W-1:0] held_vals [SLOTS];
    int unsigned       held_n;
    bit                held_dropped;

    // sorted transactions still to come, oldest first
    t_res              pending_sorted [$];
    t_res              due_res;
    int unsigned       n_fail;
    int unsigned       cycle_count;
    int                burst_left;
    logic [DATA_W-1:0] prev_value;

    dir_row_t dir_rows [DIR_N] = '{
        // single value, most negative
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
        // extremes and the sign boundary
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
        // alternating bit patterns, every bit both ways
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b1, 32'h5555_5555, 1'b1},
        // one digit per byte lane, duplicates for stability
        '{32'h0000_0100, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0100_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_00FF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hFF00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FF00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFB, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    signed_lsd_radix_sort #(
        .MAX_ITEMS (SLOTS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // bucket of a value in one pass: sign inverted on top of the byte digit,
    // so negative values land below nonnegative ones
    function automatic logic [BUCKET_W-1:0] sort_key(logic [DATA_W-1:0] v, int digit);
        return {~v[DATA_W-1], v[8*digit +: 8]};
    endfunction

    // takes one accepted transaction into the held set; on a last-marked one
    // sorts the set and queues its results (unless the table typed them in)
    function automatic void absorb_value(t_in it, bit typed);
        logic [DATA_W-1:0] src [SLOTS];
        logic [DATA_W-1:0] dst [SLOTS];
        int unsigned       tally [NUM_BUCKETS];
        logic [BUCKET_W-1:0] key;
        t_res              r;
        if (held_n < SLOTS) begin
            held_vals[held_n] = it.value;
            held_n++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!it.last)
            return;
        src = held_vals;
        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            for (int b = 0; b < NUM_BUCKETS; b++)
                tally[b] = 0;
            for (int i = 0; i < held_n; i++)
                tally[sort_key(src[i], pass)]++;
            for (int b = 1; b < NUM_BUCKETS; b++)
                tally[b] += tally[b-1];
            // walk backwards so equal keys keep their order
            for (int i = held_n - 1; i >= 0; i--) begin
                key = sort_key(src[i], pass);
                tally[key]--;
                dst[tally[key]] = src[i];
            end
            src = dst;
        end
        if (!typed) begin
            for (int i = 0; i < held_n; i++) begin
                r.sorted_value = src[i];
                r.last_res     = (i == held_n - 1);
                r.overflow     = held_dropped;
                pending_sorted.push_back(r);
            end
        end
        held_n       = 0;
        held_dropped = 1'b0;
    endfunction

    // holds the transaction on the channel until the block takes it
    task automatic send_item(t_in it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // random value: full range, near zero, extremes, repeats, sign-flipped repeats, single byte lane
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 32) - 16;
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            5:       v = prev_value;
            6: begin
                v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                v[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
            end
            default: v = prev_value ^ 32'h8000_0000;
        endcase
        prev_value = v;
        return v;
    endfunction

    // set sizes: mostly small, one full set and one that overflows
    // (drops a plain value and the last-marked one)
    function automatic int pick_size(int set_idx);
        if (set_idx == 4)
            return SLOTS + 2;
        if (set_idx == 10)
            return SLOTS;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    // result checker: every strobe must match the oldest pending transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected transaction sorted_value %h", o_result.sorted_value);
                n_fail++;
            end else begin
                due_res = pending_sorted.pop_front();
                if (o_result.sorted_value !== due_res.sorted_value) begin
                    $error("sorted_value expected %h actual %h",
                           due_res.sorted_value, o_result.sorted_value);
                    n_fail++;
                end
                if (o_result.last_res !== due_res.last_res) begin
                    $error("last_res expected %0b actual %0b",
                           due_res.last_res, o_result.last_res);
                    n_fail++;
                end
                if (o_result.overflow !== due_res.overflow) begin
                    $error("overflow expected %0b actual %0b",
                           due_res.overflow, o_result.overflow);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("signed_lsd_radix_sort_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        t_in  it;
        t_res r;
        int   set_size;
        start        = 1'b0;
        i_item       = '0;
        i_rst_n      = 1'b0;
        held_n       = 0;
        held_dropped = 1'b0;
        n_fail       = 0;
        burst_left   = 0;
        prev_value   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, back to back; typed rows queue their own result
        for (int i = 0; i < DIR_N; i++) begin
            it.value = dir_rows[i].value;
            it.last  = dir_rows[i].last;
            send_item(it);
            if (dir_rows[i].typed) begin
                r.sorted_value = dir_rows[i].exp_value;
                r.last_res     = dir_rows[i].exp_last;
                r.overflow     = 1'b0;
                pending_sorted.push_back(r);
            end
            absorb_value(it, dir_rows[i].typed);
        end

        // random sets, sender in bursts with random gaps
        for (int s = 0; s < RAND_SETS; s++) begin
            set_size = pick_size(s);
            for (int i = 0; i < set_size; i++) begin
                if (burst_left == 0) begin
                    // about one burst in four follows straight on, no gap
                    if ($urandom_range(0, 3) != 0)
                        pause_sender($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                it.value = pick_value();
                it.last  = (i == set_size - 1);
                send_item(it);
                absorb_value(it, 1'b0);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
        // catch stray transactions after the final one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && pending_sorted.size() == 0) begin
            $display("signed_lsd_radix_sort_tb: clean");
        end else begin
            $display("signed_lsd_radix_sort_tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
src/slrs_pkg.sv
src/slrs_bucket_bank.sv
src/signed_lsd_radix_sort.sv
test/signed_lsd_radix_sort_tb.sv
